// ----- hdl/sacc_pkg.sv -----
// ----------------------------------------------------------------------------
// sacc_pkg
// Shared types, constants and helpers of the cache tag controller.
// ----------------------------------------------------------------------------
package sacc_pkg;

  // width of the address and line address ports
  localparam int ADDR_W = 32;

  // one classified access waiting for the back end
  typedef struct packed {
    logic              mark_dirty;  // write in write-back mode
    logic              fwd_write;   // write in write-through mode
    logic [ADDR_W-1:0] line_addr;   // masked address, offset cleared
  } acc_t;

  // status from the back end to the front end
  typedef struct packed {
    logic clearing;                 // tag store init sweep in progress
  } back_stat_t;

  // log2 rounded down
  function automatic int floor_log2(input int v);
    int r;
    int t;
    r = 0;
    t = v;
    while (t > 1) begin
      t = t >> 1;
      r = r + 1;
    end
    return r;
  endfunction

  // mask keeping the low address bits in use
  function automatic logic [ADDR_W-1:0] addr_mask(input int bits);
    if (bits >= ADDR_W) begin
      return '1;
    end
    return ADDR_W'((64'd1 << bits) - 64'd1);
  endfunction

endpackage

// ----- hdl/sacc_front.sv -----
// ----------------------------------------------------------------------------
// sacc_front
// Input side: holds the policy register, classifies each access beat and
// pushes it into the access queue.
// ----------------------------------------------------------------------------
module sacc_front #(
  parameter int ADDR_BITS  = 32,
  parameter int LINE_BYTES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [sacc_pkg::ADDR_W-1:0]    address_i,
  input  logic                           q_full_i,
  input  sacc_pkg::back_stat_t           stat_i,
  output logic                           push_o,
  output sacc_pkg::acc_t                 push_data_o
);
  import sacc_pkg::*;

  localparam int              OFF_W    = floor_log2(LINE_BYTES);
  localparam logic [ADDR_W-1:0] AMASK  = addr_mask(ADDR_BITS);
  localparam logic [ADDR_W-1:0] OFFMASK = ADDR_W'((64'd1 << OFF_W) - 64'd1);

  logic wb_mode_q, wb_mode_d;

  // policy register, written one beat at a time
  assign cfg_ready_o = 1'b1;
  assign wb_mode_d   = (cfg_valid_i && cfg_ready_o) ? cfg_wdata_i : wb_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_mode_q <= 1'b1;
    end else begin
      wb_mode_q <= wb_mode_d;
    end
  end

  // no new accesses while the tag store is being cleared
  assign in_ready_o = !q_full_i && !stat_i.clearing;
  assign push_o     = in_valid_i && in_ready_o;

  // classify the access
  always_comb begin
    push_data_o.mark_dirty = mode_i && wb_mode_q;
    push_data_o.fwd_write  = mode_i && !wb_mode_q;
    push_data_o.line_addr  = address_i & AMASK & ~OFFMASK;
  end

endmodule

// ----- hdl/sacc_queue.sv -----
// ----------------------------------------------------------------------------
// sacc_queue
// Two-entry access queue between the front and back ends.
// ----------------------------------------------------------------------------
module sacc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sacc_pkg::acc_t  push_data_i,
  input  logic            pop_i,
  output sacc_pkg::acc_t  head_o,
  output logic            empty_o,
  output logic            full_o
);
  import sacc_pkg::*;

  acc_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign head_o  = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/sacc_back.sv -----
// ----------------------------------------------------------------------------
// sacc_back
// Back end: tag store, hit search, victim choice, LRU update and the
// result register.
// ----------------------------------------------------------------------------
module sacc_back #(
  parameter int ADDR_BITS  = 32,
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sacc_pkg::acc_t               head_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output sacc_pkg::back_stat_t         stat_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [1:0]                   way_o,
  output logic                         fill_needed_o,
  output logic [sacc_pkg::ADDR_W-1:0]  fill_line_address_o,
  output logic                         writeback_needed_o,
  output logic [sacc_pkg::ADDR_W-1:0]  victim_line_address_o,
  output logic                         forward_write_o
);
  import sacc_pkg::*;

  localparam int OFF_W    = floor_log2(LINE_BYTES);
  localparam int IDX_W    = floor_log2(SETS);
  localparam int LO       = OFF_W + IDX_W;
  localparam int ROWS     = 1 << IDX_W;
  localparam int ROW_AW   = (IDX_W > 0) ? IDX_W : 1;
  localparam int TAG_SPAN = ADDR_BITS - LO;
  localparam int TAG_W    = (TAG_SPAN > 0) ? TAG_SPAN : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [ADDR_W-1:0] AMASK    = addr_mask(ADDR_BITS);
  localparam logic [ADDR_W-1:0] ROW_MASK = ADDR_W'(ROWS - 1);
  localparam logic [WAY_W-1:0]  LRU_RANK = WAY_W'(WAYS - 1);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             vld;
    logic             drt;
    logic [WAY_W-1:0] rank;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_READ  = 3'b010,
    ST_EVAL  = 3'b100
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [ROW_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic              out_valid_q, out_valid_d;

  row_t              mem_q [ROWS];
  row_t              rd_row_q;
  acc_t              cur_q;

  logic              hit_q, fill_q, wbk_q, fwd_q;
  logic [1:0]        way_q;
  logic [ADDR_W-1:0] fill_addr_q, victim_q;

  logic              advance;
  logic [ADDR_W-1:0] head_sh, cur_sh, tag_sh;
  logic [ROW_AW-1:0] rd_idx, cur_set;
  logic [TAG_W-1:0]  cur_tag;

  logic              hit_c, inv_found;
  logic [WAY_W-1:0]  hit_way, inv_way, lru_way, sel_way;
  logic [WAY_W-1:0]  sel_rank;
  line_t             victim_ln;
  logic              wbk_c;
  logic [ADDR_W-1:0] victim_c, way_ext;
  row_t              new_row, clr_row;

  logic              mem_we;
  logic [ROW_AW-1:0] mem_waddr;
  row_t              mem_wdata;

  // set and tag of the queue head and of the access in flight
  assign head_sh = head_i.line_addr >> OFF_W;
  assign rd_idx  = ROW_AW'(head_sh & ROW_MASK);
  assign cur_sh  = cur_q.line_addr >> OFF_W;
  assign cur_set = ROW_AW'(cur_sh & ROW_MASK);
  assign tag_sh  = cur_q.line_addr >> LO;
  assign cur_tag = tag_sh[TAG_W-1:0];

  // handshake with the queue and result register
  assign pop_o          = (state_q == ST_READ) && !empty_i;
  assign advance        = (state_q == ST_EVAL) && (!out_valid_q || out_ready_i);
  assign stat_o.clearing = (state_q == ST_CLEAR);

  // hit search, first invalid way and LRU way, lowest way wins
  always_comb begin
    hit_c     = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    lru_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_row_q[w].vld && (rd_row_q[w].tag == cur_tag)) begin
        hit_c   = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!rd_row_q[w].vld) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(w);
      end
      if (rd_row_q[w].rank == LRU_RANK) begin
        lru_way = WAY_W'(w);
      end
    end
  end

  // chosen way and dirty victim
  always_comb begin
    if (hit_c) begin
      sel_way = hit_way;
    end else if (inv_found) begin
      sel_way = inv_way;
    end else begin
      sel_way = lru_way;
    end
    victim_ln = rd_row_q[sel_way];
    sel_rank  = victim_ln.rank;
    wbk_c     = !hit_c && victim_ln.vld && victim_ln.drt;
    victim_c  = wbk_c ? (((ADDR_W'(victim_ln.tag) << LO) |
                          (ADDR_W'(cur_set) << OFF_W)) & AMASK) : '0;
    way_ext   = ADDR_W'(sel_way);
  end

  // updated row: LRU shift, tag fill and dirty mark
  always_comb begin
    new_row = rd_row_q;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_row_q[w].rank < sel_rank) begin
        new_row[w].rank = WAY_W'(rd_row_q[w].rank + 1'b1);
      end
    end
    new_row[sel_way].rank = '0;
    if (hit_c) begin
      if (cur_q.mark_dirty) begin
        new_row[sel_way].drt = 1'b1;
      end
    end else begin
      new_row[sel_way].tag = cur_tag;
      new_row[sel_way].vld = 1'b1;
      new_row[sel_way].drt = cur_q.mark_dirty;
    end
  end

  // reset contents of one row
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      clr_row[w].tag  = '0;
      clr_row[w].vld  = 1'b0;
      clr_row[w].drt  = 1'b0;
      clr_row[w].rank = WAY_W'(w);
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = ROW_AW'(clr_cnt_q + 1'b1);
        if (clr_cnt_q == LAST_ROW) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (pop_o) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (advance) begin
          out_valid_d = 1'b1;
          state_d     = ST_READ;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // tag store port selection
  assign mem_we    = stat_o.clearing || advance;
  assign mem_waddr = stat_o.clearing ? clr_cnt_q : cur_set;
  assign mem_wdata = stat_o.clearing ? clr_row : new_row;

  // tag store, one row per set
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (pop_o) begin
      rd_row_q <= mem_q[rd_idx];
    end
  end

  // access in flight and result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (advance) begin
      hit_q       <= hit_c;
      way_q       <= way_ext[1:0];
      fill_q      <= !hit_c;
      fill_addr_q <= hit_c ? '0 : cur_q.line_addr;
      wbk_q       <= wbk_c;
      victim_q    <= victim_c;
      fwd_q       <= cur_q.fwd_write;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign hit_o                 = hit_q;
  assign way_o                 = way_q;
  assign fill_needed_o         = fill_q;
  assign fill_line_address_o   = fill_addr_q;
  assign writeback_needed_o    = wbk_q;
  assign victim_line_address_o = victim_q;
  assign forward_write_o       = fwd_q;

`ifndef SYNTHESIS
  // no access leaves the queue during the init sweep
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !pop_o)
    else $error("access popped during tag store clear");

  // finishing an access presents a result beat
  a_eval_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && (state_q == ST_READ)))
    else $error("finished access gave no result");

  // a writeback only comes with a fill
  a_wbk_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && writeback_needed_o) |-> (fill_needed_o && !hit_o))
    else $error("writeback reported without a miss");

  // a hit way is a valid line
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EVAL) && hit_c) |-> victim_ln.vld)
    else $error("hit on an invalid line");
`endif

endmodule

// ----- hdl/set_assoc_cache_tag_controller_top.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_top
// Tag and LRU policy controller of a set-associative cache with selectable
// write-back or write-through handling.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+------------------------------
//  cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_wdata_i (policy, 1 = write-back)
//  in       | in  | in_valid_i/in_ready_o   | mode_i, address_i
//  out      | out | out_valid_o/out_ready_i | hit, way, fill, writeback, forward flags
//
// In the back end an access first has the registered set row read of the tag
// store, then compare, victim choice and row write, which wait while the result register holds an untaken beat.
// After reset the tag store is cleared one set per cycle, 2**floor(log2(SETS))
// sets in all, while in_ready_o stays low; cfg writes are taken throughout.
// A two-entry queue lets the input side take beats while the back end waits
// on out_ready_i; the result register holds a finished beat until taken.
module set_assoc_cache_tag_controller_top #(
  parameter int ADDR_BITS  = 32,
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [sacc_pkg::ADDR_W-1:0]  address_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [1:0]                   way_o,
  output logic                         fill_needed_o,
  output logic [sacc_pkg::ADDR_W-1:0]  fill_line_address_o,
  output logic                         writeback_needed_o,
  output logic [sacc_pkg::ADDR_W-1:0]  victim_line_address_o,
  output logic                         forward_write_o
);
  import sacc_pkg::*;

  logic       push, pop, q_empty, q_full;
  acc_t       push_data, head;
  back_stat_t stat;

  // input side and policy register
  sacc_front #(
    .ADDR_BITS (ADDR_BITS),
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .address_i  (address_i),
    .q_full_i   (q_full),
    .stat_i     (stat),
    .push_o     (push),
    .push_data_o(push_data)
  );

  // access queue
  sacc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // tag store and policy
  sacc_back #(
    .ADDR_BITS (ADDR_BITS),
    .SETS      (SETS),
    .WAYS      (WAYS),
    .LINE_BYTES(LINE_BYTES)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .head_i               (head),
    .empty_i              (q_empty),
    .pop_o                (pop),
    .stat_o               (stat),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .hit_o                (hit_o),
    .way_o                (way_o),
    .fill_needed_o        (fill_needed_o),
    .fill_line_address_o  (fill_line_address_o),
    .writeback_needed_o   (writeback_needed_o),
    .victim_line_address_o(victim_line_address_o),
    .forward_write_o      (forward_write_o)
  );

endmodule
